// ===== hw/rtl/rehs_pkg.sv =====
// Shared field widths, request codes and register indexes of the ring exclusion hop step.
`timescale 1ns / 1ps

package rehs_pkg;

    localparam int PART_W     = 10;
    localparam int SITE_W     = 12;
    localparam int PROB_W     = 16;
    localparam int DISP_W     = 13;
    localparam int RING_W     = 13;
    localparam int TRC_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_HOP  = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_SITES    = 2'd0,
        CFG_TRACER_COUNT  = 2'd1,
        CFG_DEFAULT_PROB  = 2'd2
    } t_cfg_index;

endpackage

// ===== hw/rtl/rehs_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module rehs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/ring_exclusion_hop_step.sv =====
// Top level of the ring exclusion hop step: particle and occupancy memories and their sequencer.
`timescale 1ns / 1ps

// Particles sit on a ring of sites, at most one to a site. A load word places a particle and
// records its start site and own right-hop probability; a hop word moves it one site right or
// left, chosen by comparing the uniform fraction with its own probability (with the default
// probability for particles at or above the tracer count), but only onto an empty site. Each
// input word gives exactly one result word: moved flag, particle, site and the displacement
// from the start site, wrapped into (-L/2, L/2]. One word is handled at a time: the particle
// memory is read once, then the occupancy memory is read up to twice and written up to twice
// through its one read port and one write port. A result still held in the result register
// by the receiver holds the sequencer until it is taken. When the site and start site lie a
// ring length or more apart (after the ring has been shrunk), the displacement remainder is
// found one bit a cycle. After reset the occupancy memory is swept to empty, and no word is
// taken during the sweep; configuration writes are taken throughout.
module ring_exclusion_hop_step #(
    parameter int MAX_SITES     = 4096,
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_wr_en,
    input  logic [rehs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rehs_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [rehs_pkg::PART_W-1:0]        i_particle,
    input  logic [rehs_pkg::SITE_W-1:0]        i_site,
    input  logic [rehs_pkg::PROB_W-1:0]        i_right_prob,
    input  logic [rehs_pkg::PROB_W-1:0]        i_uniform,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_moved,
    output logic [rehs_pkg::PART_W-1:0]        o_which_particle,
    output logic [rehs_pkg::SITE_W-1:0]        o_new_site,
    output logic signed [rehs_pkg::DISP_W-1:0] o_displacement
);

    import rehs_pkg::*;

    localparam int SW  = $clog2(MAX_SITES);
    localparam int LW  = $clog2(MAX_SITES + 1);
    localparam int PW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int OW  = PW + 1;
    localparam int CW  = $clog2(SW + 1);
    localparam int PMW = 2 * SW + PROB_W;

    localparam logic [OW-1:0] EMPTY_OWNER = {OW{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREAD,
        S_RD1,
        S_RD2,
        S_WR1,
        S_WR2,
        S_DISP,
        S_MOD,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [SW-1:0]       r_clr_cnt;

    logic [RING_W-1:0]   r_ring_sites;
    logic [TRC_W-1:0]    r_tracer;
    logic [PROB_W-1:0]   r_default_prob;

    logic                r_req;
    logic [PART_W-1:0]   r_particle;
    logic [SITE_W-1:0]   r_site_in;
    logic [PROB_W-1:0]   r_rp;
    logic [PROB_W-1:0]   r_uniform;

    logic [SW-1:0]       r_pos;
    logic [SW-1:0]       r_start;
    logic [PROB_W-1:0]   r_prob;
    logic                r_own_pos;
    logic [SW-1:0]       r_dst;
    logic                r_moved;
    logic [SW-1:0]       r_pos_out;
    logic [SW-1:0]       r_start_out;

    logic                r_neg;
    logic [LW-1:0]       r_rem;
    logic [SW-1:0]       r_div;
    logic [CW-1:0]       r_cnt;

    logic                r_out_valid;
    logic                r_out_moved;
    logic [PART_W-1:0]   r_out_particle;
    logic [SITE_W-1:0]   r_out_site;
    logic [DISP_W-1:0]   r_out_disp;

    // Memory ports.
    logic [PW-1:0]       part_rd_addr;
    logic [PMW-1:0]      part_rd_data;
    logic                part_wr_en;
    logic [PMW-1:0]      part_wr_data;
    logic [SW-1:0]       own_rd_addr;
    logic [OW-1:0]       own_rd_data;
    logic                own_wr_en;
    logic [SW-1:0]       own_wr_addr;
    logic [OW-1:0]       own_wr_data;

    logic [LW-1:0]       ring_len;
    logic                in_accept;
    logic                out_free;
    logic [OW-1:0]       self_owner;
    logic                pos_in_ring;
    logic                site_in_ring;
    logic                go_right;
    logic [SW:0]         pos_inc;
    logic [SW-1:0]       target;
    logic signed [SW:0]  diff;
    logic [SW-1:0]       abs_diff;
    logic [LW:0]         mod_trial;
    logic [LW-1:0]       rem_pos;
    logic signed [LW:0]  disp_full;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign self_owner = {1'b0, PW'(r_particle)};

    // The ring length in use is the register saturated into [2, MAX_SITES].
    always_comb begin
        if (32'(r_ring_sites) > MAX_SITES) begin
            ring_len = LW'(MAX_SITES);
        end else if (r_ring_sites < RING_W'(2)) begin
            ring_len = LW'(2);
        end else begin
            ring_len = LW'(r_ring_sites);
        end
    end

    always_comb begin
        pos_in_ring  = 32'(r_pos) < 32'(ring_len);
        site_in_ring = 32'(r_site_in) < 32'(ring_len);
        if (32'(r_particle) < 32'(r_tracer)) begin
            go_right = r_uniform < r_prob;
        end else begin
            go_right = r_uniform < r_default_prob;
        end
        pos_inc = {1'b0, r_pos} + (SW + 1)'(1);
        if (go_right) begin
            target = (32'(pos_inc) >= 32'(ring_len)) ? '0 : SW'(pos_inc);
        end else begin
            target = (r_pos == '0) ? SW'(ring_len - LW'(1)) : r_pos - SW'(1);
        end
    end

    always_comb begin
        diff      = $signed({1'b0, r_pos_out}) - $signed({1'b0, r_start_out});
        abs_diff  = diff[SW] ? SW'(-diff) : SW'(diff);
        mod_trial = {r_rem, r_div[SW-1]};
        rem_pos   = (r_neg && r_rem != '0) ? ring_len - r_rem : r_rem;
        if (rem_pos > (ring_len >> 1)) begin
            disp_full = $signed({1'b0, rem_pos}) - $signed({1'b0, ring_len});
        end else begin
            disp_full = $signed({1'b0, rem_pos});
        end
    end

    always_comb begin
        part_rd_addr = PW'(i_particle);
        part_wr_en   = 1'b0;
        part_wr_data = {SW'(r_site_in), SW'(r_site_in), r_rp};
        own_rd_addr  = SW'(part_rd_data[PMW-1 -: SW]);
        own_wr_en    = 1'b0;
        own_wr_addr  = r_pos;
        own_wr_data  = EMPTY_OWNER;
        unique case (r_state)
            S_CLEAR: begin
                own_wr_en   = 1'b1;
                own_wr_addr = r_clr_cnt;
            end
            S_RD1: begin
                own_rd_addr = (r_req == REQ_LOAD) ? SW'(r_site_in) : target;
            end
            S_RD2: begin
                if (r_req == REQ_LOAD) begin
                    part_wr_en = site_in_ring &&
                                 (own_rd_data == EMPTY_OWNER || own_rd_data == self_owner);
                end else begin
                    part_wr_en   = own_rd_data == EMPTY_OWNER;
                    part_wr_data = {r_dst, r_start, r_prob};
                end
            end
            S_WR1: begin
                own_wr_en = 1'b1;
            end
            S_WR2: begin
                own_wr_en   = 1'b1;
                own_wr_addr = r_dst;
                own_wr_data = self_owner;
            end
            default: begin
            end
        endcase
    end

    rehs_ram #(
        .WIDTH (PMW),
        .DEPTH (MAX_PARTICLES)
    ) u_part_ram (
        .i_clk     (i_clk),
        .i_wr_en   (part_wr_en),
        .i_wr_addr (PW'(r_particle)),
        .i_wr_data (part_wr_data),
        .i_rd_addr (part_rd_addr),
        .o_rd_data (part_rd_data)
    );

    rehs_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_SITES)
    ) u_owner_ram (
        .i_clk     (i_clk),
        .i_wr_en   (own_wr_en),
        .i_wr_addr (own_wr_addr),
        .i_wr_data (own_wr_data),
        .i_rd_addr (own_rd_addr),
        .o_rd_data (own_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_cnt      <= '0;
            r_ring_sites   <= RING_W'(4096);
            r_tracer       <= TRC_W'(1);
            r_default_prob <= PROB_W'(32768);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_RING_SITES:   r_ring_sites   <= RING_W'(i_cfg_data);
                    CFG_TRACER_COUNT: r_tracer       <= TRC_W'(i_cfg_data);
                    CFG_DEFAULT_PROB: r_default_prob <= PROB_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            // In the final state the result register is reloaded below instead.
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + SW'(1);
                    if (r_clr_cnt == SW'(MAX_SITES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_req      <= i_req_type;
                        r_particle <= i_particle;
                        r_site_in  <= i_site;
                        r_rp       <= i_right_prob;
                        r_uniform  <= i_uniform;
                        r_moved    <= 1'b0;
                        if (32'(i_particle) >= MAX_PARTICLES) begin
                            // Unknown particle: report site and displacement zero.
                            r_pos_out   <= '0;
                            r_start_out <= '0;
                            r_state     <= S_DISP;
                        end else begin
                            r_state <= S_PREAD;
                        end
                    end
                end
                S_PREAD: begin
                    r_pos   <= part_rd_data[PMW-1 -: SW];
                    r_start <= part_rd_data[SW+PROB_W-1 -: SW];
                    r_prob  <= part_rd_data[PROB_W-1:0];
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_own_pos   <= own_rd_data == self_owner;
                    r_dst       <= target;
                    r_pos_out   <= r_pos;
                    r_start_out <= r_start;
                    if (r_req == REQ_HOP && (!pos_in_ring || own_rd_data != self_owner)) begin
                        r_state <= S_DISP;
                    end else begin
                        r_state <= S_RD2;
                    end
                end
                S_RD2: begin
                    if (r_req == REQ_LOAD) begin
                        if (site_in_ring &&
                            (own_rd_data == EMPTY_OWNER || own_rd_data == self_owner)) begin
                            r_dst       <= SW'(r_site_in);
                            r_pos_out   <= SW'(r_site_in);
                            r_start_out <= SW'(r_site_in);
                            r_state     <= r_own_pos ? S_WR1 : S_WR2;
                        end else begin
                            r_state <= S_DISP;
                        end
                    end else begin
                        if (own_rd_data == EMPTY_OWNER) begin
                            r_moved   <= 1'b1;
                            r_pos_out <= r_dst;
                            r_state   <= S_WR1;
                        end else begin
                            r_state <= S_DISP;
                        end
                    end
                end
                S_WR1: begin
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_neg <= diff[SW];
                    if (32'(abs_diff) < 32'(ring_len)) begin
                        r_rem   <= LW'(abs_diff);
                        r_state <= S_FIN;
                    end else begin
                        // Both sites far apart on a short ring: restoring remainder.
                        r_rem   <= '0;
                        r_div   <= abs_diff;
                        r_cnt   <= CW'(SW);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (32'(mod_trial) >= 32'(ring_len)) begin
                        r_rem <= LW'(mod_trial - (LW + 1)'(ring_len));
                    end else begin
                        r_rem <= LW'(mod_trial);
                    end
                    r_div <= r_div << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_moved    <= r_moved;
                        r_out_particle <= r_particle;
                        r_out_site     <= SITE_W'(r_pos_out);
                        r_out_disp     <= DISP_W'(disp_full);
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = r_state != S_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_moved          = r_out_moved;
    assign o_which_particle = r_out_particle;
    assign o_new_site       = r_out_site;
    assign o_displacement   = $signed(r_out_disp);

endmodule
